// ===== hdl/iep_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iep_pkg: shared types and constants of the absolute pointer block
// Event codes, the command passed from the decoder to the executor through
// the command queue, the report layout and the reset values of the state.
// ----------------------------------------------------------------------------
package iep_pkg;

  // Event classes and codes
  localparam logic [15:0] TypeSync   = 16'h0000;
  localparam logic [15:0] TypeKey    = 16'h0001;
  localparam logic [15:0] TypeAbs    = 16'h0003;
  localparam logic [15:0] CodeReport = 16'h0001;
  localparam logic [15:0] AxisX      = 16'h0000;
  localparam logic [15:0] AxisY      = 16'h0001;
  localparam logic [15:0] KeyLeft    = 16'h0110;
  localparam logic [15:0] KeyRight   = 16'h0111;
  localparam logic [15:0] KeyMiddle  = 16'h0112;

  // Button mask bits
  localparam logic [2:0] BtnLeft   = 3'b001;
  localparam logic [2:0] BtnRight  = 3'b010;
  localparam logic [2:0] BtnMiddle = 3'b100;

  // Configuration register indexes
  localparam logic [2:0] RegXMin   = 3'd0;
  localparam logic [2:0] RegXMax   = 3'd1;
  localparam logic [2:0] RegYMin   = 3'd2;
  localparam logic [2:0] RegYMax   = 3'd3;
  localparam logic [2:0] RegXLimit = 3'd4;
  localparam logic [2:0] RegYLimit = 3'd5;

  // Reset values
  localparam logic [31:0] AxisMinReset = 32'd0;
  localparam logic [31:0] AxisMaxReset = 32'd32767;
  localparam logic [15:0] XLimitReset  = 16'd1919;
  localparam logic [15:0] YLimitReset  = 16'd1079;
  localparam logic [15:0] PosXReset    = 16'd960;
  localparam logic [15:0] PosYReset    = 16'd540;

  // Divisor used when an axis range is empty
  localparam logic [31:0] FallbackSpan = 32'd32767;

  // Divider geometry: 48-bit dividend, 32-bit divisor, one bit per cycle
  localparam int NumWidth  = 48;
  localparam int DenWidth  = 32;
  localparam int DivSteps  = NumWidth;
  localparam int CntWidth  = $clog2(DivSteps);

  // Command queue
  localparam int QueueDepth = 4;
  localparam int PtrWidth   = $clog2(QueueDepth);
  localparam int CountWidth = $clog2(QueueDepth + 1);

  // Decoded command kinds
  typedef enum logic [1:0] {
    OP_SET_X,
    OP_SET_Y,
    OP_KEY,
    OP_REPORT
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  key_mask;
    logic [31:0] value;
  } cmd_t;

  // Queue handshake toward the executor
  typedef struct packed {
    logic empty;
    cmd_t head;
  } queue_status_t;

  // One pointer report
  typedef struct packed {
    logic [2:0]  button_mask;
    logic [15:0] pointer_y;
    logic [15:0] pointer_x;
  } report_t;

  // Executor states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PREP,
    BK_MUL,
    BK_START,
    BK_DIV,
    BK_EMIT
  } back_state_t;

endpackage

// ===== hdl/iep_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iep_front: event decoder
// Accepts input events, drops the ones that do nothing and pushes a decoded
// command for every axis, button or report event into the command queue.
// ----------------------------------------------------------------------------
module iep_front (
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [15:0]   event_type,
  input  logic [15:0]   event_code,
  input  logic [31:0]   event_value,
  input  logic          queue_full,
  output logic          push,
  output iep_pkg::cmd_t cmd
);

  logic keep;

  // Accept whenever the queue has room
  assign in_tready = ~queue_full;

  // Classify the event
  always_comb begin
    keep         = 1'b0;
    cmd.op       = iep_pkg::OP_KEY;
    cmd.key_mask = 3'b000;
    cmd.value    = event_value;
    case (event_type)
      iep_pkg::TypeAbs: begin
        if (event_code == iep_pkg::AxisX) begin
          keep   = 1'b1;
          cmd.op = iep_pkg::OP_SET_X;
        end else if (event_code == iep_pkg::AxisY) begin
          keep   = 1'b1;
          cmd.op = iep_pkg::OP_SET_Y;
        end
      end
      iep_pkg::TypeKey: begin
        cmd.op = iep_pkg::OP_KEY;
        case (event_code)
          iep_pkg::KeyLeft: begin
            keep         = 1'b1;
            cmd.key_mask = iep_pkg::BtnLeft;
          end
          iep_pkg::KeyRight: begin
            keep         = 1'b1;
            cmd.key_mask = iep_pkg::BtnRight;
          end
          iep_pkg::KeyMiddle: begin
            keep         = 1'b1;
            cmd.key_mask = iep_pkg::BtnMiddle;
          end
          default: keep = 1'b0;
        endcase
      end
      iep_pkg::TypeSync: begin
        if (event_code == iep_pkg::CodeReport) begin
          keep   = 1'b1;
          cmd.op = iep_pkg::OP_REPORT;
        end
      end
      default: keep = 1'b0;
    endcase
  end

  assign push = in_tvalid & in_tready & keep;

endmodule

// ===== hdl/iep_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iep_queue: command queue
// Short first-word-fall-through queue between the decoder and the executor.
// ----------------------------------------------------------------------------
module iep_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  iep_pkg::cmd_t          push_cmd,
  input  logic                   pop,
  output logic                   full,
  output iep_pkg::queue_status_t status
);

  iep_pkg::cmd_t                        mem_r [iep_pkg::QueueDepth];
  logic [iep_pkg::PtrWidth-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [iep_pkg::PtrWidth-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [iep_pkg::CountWidth-1:0]       count_r, count_nxt;
  logic                                 do_push, do_pop;

  assign full         = (count_r == iep_pkg::CountWidth'(iep_pkg::QueueDepth));
  assign status.empty = (count_r == '0);
  assign status.head  = mem_r[rd_ptr_r];

  assign do_push = push & ~full;
  assign do_pop  = pop & ~status.empty;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hdl/iep_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iep_div: serial unsigned divider
// Restoring division of a 48-bit dividend by a 32-bit divisor, one quotient
// bit per cycle. done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module iep_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [iep_pkg::NumWidth-1:0]  numer,
  input  logic [iep_pkg::DenWidth-1:0]  denom,
  output logic                          done,
  output logic [iep_pkg::NumWidth-1:0]  quotient
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [iep_pkg::CntWidth-1:0]  cnt_r, cnt_nxt;
  logic [iep_pkg::NumWidth-1:0]  work_r, work_nxt;
  logic [iep_pkg::DenWidth-1:0]  rem_r, rem_nxt;
  logic [iep_pkg::DenWidth-1:0]  den_r, den_nxt;
  logic [iep_pkg::DenWidth:0]    trial;
  logic [iep_pkg::DenWidth:0]    diff;
  logic                          fits;

  // One restoring step
  assign trial = {rem_r, work_r[iep_pkg::NumWidth-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    work_nxt = work_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      work_nxt = numer;
      rem_nxt  = '0;
      den_nxt  = denom;
    end else if (busy_r) begin
      work_nxt = {work_r[iep_pkg::NumWidth-2:0], fits};
      rem_nxt  = fits ? diff[iep_pkg::DenWidth-1:0] : trial[iep_pkg::DenWidth-1:0];
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == iep_pkg::CntWidth'(iep_pkg::DivSteps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = work_r;

endmodule

// ===== hdl/iep_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iep_back: command executor
// Holds the configuration and pointer state, carries out queued commands,
// rescales pending axes through the serial divider and drives the report
// output register.
// ----------------------------------------------------------------------------
module iep_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [2:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  input  iep_pkg::queue_status_t status,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output iep_pkg::report_t       report
);

  // Configuration
  logic signed [31:0] x_min_r, x_max_r, y_min_r, y_max_r;
  logic [15:0]        x_lim_r, y_lim_r;

  // Pointer state
  logic [31:0] raw_x_r, raw_x_nxt;
  logic [31:0] raw_y_r, raw_y_nxt;
  logic        x_pend_r, x_pend_nxt;
  logic        y_pend_r, y_pend_nxt;
  logic [15:0] pos_x_r, pos_x_nxt;
  logic [15:0] pos_y_r, pos_y_nxt;
  logic [2:0]  btn_r, btn_nxt;

  // Rescale datapath
  iep_pkg::back_state_t state_r, state_nxt;
  logic        axis_y_r, axis_y_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic [31:0] den_r, den_nxt;
  logic [47:0] prod_r, prod_nxt;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  iep_pkg::report_t report_r, report_nxt;

  // Axis selection
  logic signed [31:0] sel_raw, sel_lo, sel_hi;
  logic [15:0]        sel_lim;
  logic               range_empty;
  logic signed [32:0] diff_full;
  logic signed [32:0] span_full;
  logic [15:0]        scaled;

  logic        div_start;
  logic        div_done;
  logic [47:0] div_quo;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r <= iep_pkg::AxisMinReset;
      x_max_r <= iep_pkg::AxisMaxReset;
      y_min_r <= iep_pkg::AxisMinReset;
      y_max_r <= iep_pkg::AxisMaxReset;
      x_lim_r <= iep_pkg::XLimitReset;
      y_lim_r <= iep_pkg::YLimitReset;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        iep_pkg::RegXMin:   x_min_r <= cfg_data;
        iep_pkg::RegXMax:   x_max_r <= cfg_data;
        iep_pkg::RegYMin:   y_min_r <= cfg_data;
        iep_pkg::RegYMax:   y_max_r <= cfg_data;
        iep_pkg::RegXLimit: x_lim_r <= cfg_data[15:0];
        iep_pkg::RegYLimit: y_lim_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Select the axis being rescaled
  always_comb begin
    sel_raw     = axis_y_r ? raw_y_r : raw_x_r;
    sel_lo      = axis_y_r ? y_min_r : x_min_r;
    sel_hi      = axis_y_r ? y_max_r : x_max_r;
    sel_lim     = axis_y_r ? y_lim_r : x_lim_r;
    range_empty = (sel_hi <= sel_lo);
    span_full   = {sel_hi[31], sel_hi} - {sel_lo[31], sel_lo};
    if (range_empty) begin
      diff_full = {sel_raw[31], sel_raw};
    end else begin
      diff_full = {sel_raw[31], sel_raw} - {sel_lo[31], sel_lo};
    end
  end

  // Clamp the quotient to 0..limit
  always_comb begin
    if (neg_r) begin
      scaled = 16'd0;
    end else if (div_quo > {32'd0, sel_lim}) begin
      scaled = sel_lim;
    end else begin
      scaled = div_quo[15:0];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    axis_y_nxt    = axis_y_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    den_nxt       = den_r;
    prod_nxt      = prod_r;
    raw_x_nxt     = raw_x_r;
    raw_y_nxt     = raw_y_r;
    x_pend_nxt    = x_pend_r;
    y_pend_nxt    = y_pend_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    btn_nxt       = btn_r;
    report_nxt    = report_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    pop           = 1'b0;
    div_start     = 1'b0;

    case (state_r)
      iep_pkg::BK_IDLE: begin
        if (!status.empty) begin
          pop = 1'b1;
          case (status.head.op)
            iep_pkg::OP_SET_X: begin
              raw_x_nxt  = status.head.value;
              x_pend_nxt = 1'b1;
            end
            iep_pkg::OP_SET_Y: begin
              raw_y_nxt  = status.head.value;
              y_pend_nxt = 1'b1;
            end
            iep_pkg::OP_KEY: begin
              btn_nxt = (btn_r & ~status.head.key_mask)
                      | ((status.head.value != '0) ? status.head.key_mask : 3'b000);
            end
            iep_pkg::OP_REPORT: begin
              if (x_pend_r) begin
                axis_y_nxt = 1'b0;
                state_nxt  = iep_pkg::BK_PREP;
              end else if (y_pend_r) begin
                axis_y_nxt = 1'b1;
                state_nxt  = iep_pkg::BK_PREP;
              end else begin
                state_nxt = iep_pkg::BK_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      // Offset the raw value by the axis minimum unless the range is empty, and pick the divisor
      iep_pkg::BK_PREP: begin
        neg_nxt   = diff_full[32];
        mag_nxt   = diff_full[31:0];
        den_nxt   = range_empty ? iep_pkg::FallbackSpan : span_full[31:0];
        state_nxt = iep_pkg::BK_MUL;
      end
      // Scale by the screen limit
      iep_pkg::BK_MUL: begin
        prod_nxt  = mag_r * sel_lim;
        state_nxt = iep_pkg::BK_START;
      end
      iep_pkg::BK_START: begin
        div_start = 1'b1;
        state_nxt = iep_pkg::BK_DIV;
      end
      // Wait for the quotient, then move to the other axis or report
      iep_pkg::BK_DIV: begin
        if (div_done) begin
          if (axis_y_r) begin
            pos_y_nxt = scaled;
            state_nxt = iep_pkg::BK_EMIT;
          end else begin
            pos_x_nxt = scaled;
            if (y_pend_r) begin
              axis_y_nxt = 1'b1;
              state_nxt  = iep_pkg::BK_PREP;
            end else begin
              state_nxt = iep_pkg::BK_EMIT;
            end
          end
        end
      end
      // Load the output register once it is free
      iep_pkg::BK_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt          = 1'b1;
          report_nxt.pointer_x   = pos_x_r;
          report_nxt.pointer_y   = pos_y_r;
          report_nxt.button_mask = btn_r;
          x_pend_nxt             = 1'b0;
          y_pend_nxt             = 1'b0;
          state_nxt              = iep_pkg::BK_IDLE;
        end
      end
      default: state_nxt = iep_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iep_pkg::BK_IDLE;
      axis_y_r    <= 1'b0;
      raw_x_r     <= '0;
      raw_y_r     <= '0;
      x_pend_r    <= 1'b0;
      y_pend_r    <= 1'b0;
      pos_x_r     <= iep_pkg::PosXReset;
      pos_y_r     <= iep_pkg::PosYReset;
      btn_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_y_r    <= axis_y_nxt;
      raw_x_r     <= raw_x_nxt;
      raw_y_r     <= raw_y_nxt;
      x_pend_r    <= x_pend_nxt;
      y_pend_r    <= y_pend_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      btn_r       <= btn_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    neg_r    <= neg_nxt;
    mag_r    <= mag_nxt;
    den_r    <= den_nxt;
    prod_r   <= prod_nxt;
    report_r <= report_nxt;
  end

  iep_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .numer    (prod_r),
    .denom    (den_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_tvalid = out_valid_r;
  assign report     = report_r;

endmodule

// ===== hdl/input_event_to_absolute_pointer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_event_to_absolute_pointer: absolute pointer from input events
// Turns a stream of input events into scaled pointer reports.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one input event per transaction. Absolute X/Y events latch a raw
//           value, left/right/middle key events update the button mask, a
//           sync report event produces one transaction on out_*. Other
//           events are dropped.
//   out_* : one pointer report per sync report event.
//   cfg_* : axis ranges and screen limits; write only while the block idles.
// Timing: the decoder accepts an event per cycle while the four-entry
//   command queue has room. The executor carries out an axis or key event
//   straight from idle. A report rescales each pending axis in turn, X first,
//   through the serial divider shared by both axes, then emits.
// Reset: rst_n low clears the queue and the output, sets the position to
//   960,540, buttons to zero and registers to their defaults.
// Stall: a report waits in the output register while out_tready is low;
//   events still queue until the command queue fills, then in_tready drops.
// ----------------------------------------------------------------------------
module input_event_to_absolute_pointer (
  input  logic        clk,
  input  logic        rst_n,
  // event_type, event_code, event_value
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  // pointer_x, pointer_y, button_mask, zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic                   push;
  logic                   pop;
  logic                   queue_full;
  iep_pkg::cmd_t          cmd;
  iep_pkg::queue_status_t status;
  iep_pkg::report_t       report;

  iep_front u_front (
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .event_type  (in_tdata[15:0]),
    .event_code  (in_tdata[31:16]),
    .event_value (in_tdata[63:32]),
    .queue_full  (queue_full),
    .push        (push),
    .cmd         (cmd)
  );

  iep_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (cmd),
    .pop      (pop),
    .full     (queue_full),
    .status   (status)
  );

  iep_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .status     (status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .report     (report)
  );

  // Pack the report, lowest field first
  assign out_tdata = {5'b00000, report.button_mask, report.pointer_y, report.pointer_x};

endmodule

// ===== hdl/iep_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iep_checker: port-level checks of the absolute pointer block
// Watches the report channel, and the input handshake out of reset, and is bound to the top level.
// ----------------------------------------------------------------------------
module iep_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // Hold a stalled report
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("report dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("report changed while stalled");

  // Fill bits above the button mask stay zero
  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:35] == 5'b00000)
    else $error("report fill bits set");

  // Reset empties the output
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("report valid after reset");

  // Checks only the first cycle out of reset: with no event accepted there, no report may follow
  a_no_early_report: assert property (@(posedge clk)
    $past(!rst_n) && !(in_tvalid && in_tready) |=> !out_tvalid)
    else $error("report without an event");

endmodule

bind input_event_to_absolute_pointer iep_checker u_iep_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
